// ===== hw/rtl/cma_pkg.sv =====
// package for the centered moving average unit
// holds shared widths and default parameter values, no dependencies
package cma_pkg;

    localparam int CFG_BITS        = 6;
    localparam int DEF_MAX_WINDOW  = 63;
    localparam int DEF_SAMPLE_BITS = 16;

endpackage

// ===== hw/rtl/cma_cell.sv =====
// one storage cell of the window delay line
// no dependencies beyond the clock
module cma_cell #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_shift,
    input  logic                   i_inject,
    input  logic [SAMPLE_BITS-1:0] i_new,
    input  logic [SAMPLE_BITS-1:0] i_neighbor,
    output logic [SAMPLE_BITS-1:0] o_q
);

    logic [SAMPLE_BITS-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_q <= i_inject ? i_new : i_neighbor;
        end
    end

    assign o_q = r_q;

endmodule

// ===== hw/rtl/cma_div.sv =====
// iterative restoring divider, one quotient bit per cycle
// no package dependencies
module cma_div #(
    parameter int NUM_BITS = 22,
    parameter int DEN_BITS = 6
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [NUM_BITS-1:0] i_num,
    input  logic [DEN_BITS-1:0] i_den,
    output logic                o_done,
    output logic [NUM_BITS-1:0] o_quo
);

    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic                r_busy;
    logic                r_done;
    logic [CNT_BITS-1:0] r_cnt;
    logic [DEN_BITS-1:0] r_rem;
    logic [DEN_BITS-1:0] r_den;
    logic [NUM_BITS-1:0] r_quo;
    logic [DEN_BITS:0]   trial;
    logic                ge;
    logic [DEN_BITS:0]   diff;

    assign trial = {r_rem, r_quo[NUM_BITS-1]};
    assign ge    = trial >= {1'b0, r_den};
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(NUM_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_quo <= i_num;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
            r_quo <= {r_quo[NUM_BITS-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ===== hw/rtl/centered_moving_average_unit.sv =====
// Centered moving average over an odd window with edge replication. Each
// accepted word causes one push per cycle into a chain of sample cells (extra
// pushes of the first and last sample pad the stream ends), except that every
// push that fills the window runs the bit-serial divider and then loads the
// output register, waiting while the output stalls, before the next push.
// Output lags input by half the window.
// depends on cma_pkg, cma_cell and cma_div
module centered_moving_average_unit #(
    parameter int MAX_WINDOW  = cma_pkg::DEF_MAX_WINDOW,
    parameter int SAMPLE_BITS = cma_pkg::DEF_SAMPLE_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [SAMPLE_BITS-1:0]       i_sample_in,
    input  logic                         i_end_of_stream,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [SAMPLE_BITS-1:0]       o_sample_out,
    output logic                         o_last_out,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [cma_pkg::CFG_BITS-1:0] i_cfg_data
);

    import cma_pkg::*;

    localparam int CAP      = (MAX_WINDOW - 1) | 1;
    localparam int SUM_BITS = SAMPLE_BITS + CFG_BITS;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PUSH = 4'b0010,
        S_DIV  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state                       r_state;
    logic [CFG_BITS-1:0]          r_ws;
    logic [CFG_BITS-1:0]          r_seen;
    logic [CFG_BITS-1:0]          r_npush;
    logic signed [SUM_BITS-1:0]   r_sum;
    logic [SAMPLE_BITS-1:0]       r_smp;
    logic                         r_lastitem;
    logic                         r_neg;
    logic                         r_ovalid;
    logic [SAMPLE_BITS-1:0]       r_out;
    logic                         r_olast;

    logic [CFG_BITS-1:0]          w_eff;
    logic [CFG_BITS-1:0]          half;
    logic [SAMPLE_BITS-1:0]       cell_q [MAX_WINDOW+1];
    logic                         shift;
    logic signed [SUM_BITS-1:0]   n_sum;
    logic [CFG_BITS-1:0]          n_seen;
    logic [SUM_BITS-1:0]          mag;
    logic                         div_start;
    logic                         div_done;
    logic [SUM_BITS-1:0]          quo;
    logic [SAMPLE_BITS-1:0]       res;
    logic                         out_free;
    logic [SUM_BITS-1:0]          lim;

    assign w_eff = (int'(r_ws) > CAP) ? CFG_BITS'(CAP) : r_ws;
    assign half  = w_eff >> 1;
    assign shift = (r_state == S_PUSH);

    assign cell_q[MAX_WINDOW] = '0;
    for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
        cma_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
            .i_clk      (i_clk),
            .i_shift    (shift),
            .i_inject   (int'(w_eff) - 1 == g),
            .i_new      (r_smp),
            .i_neighbor (cell_q[g+1]),
            .o_q        (cell_q[g])
        );
    end

    // cell 0 holds the oldest entry of the full window
    always_comb begin
        n_sum = r_sum + SUM_BITS'($signed(r_smp));
        if (r_seen >= w_eff) begin
            n_sum = n_sum - SUM_BITS'($signed(cell_q[0]));
        end
        n_seen = (r_seen < w_eff) ? r_seen + 1'b1 : r_seen;
    end

    assign mag       = (n_sum[SUM_BITS-1] ? SUM_BITS'(-n_sum) : SUM_BITS'(n_sum))
                       + SUM_BITS'(half);
    assign div_start = shift && (n_seen == w_eff);

    cma_div #(.NUM_BITS(SUM_BITS), .DEN_BITS(CFG_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (mag),
        .i_den   (w_eff),
        .o_done  (div_done),
        .o_quo   (quo)
    );

    assign lim = SUM_BITS'(1) << (SAMPLE_BITS - 1);

    // saturate to the signed sample range
    always_comb begin
        if (r_neg) begin
            res = (quo >= lim) ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                               : SAMPLE_BITS'(-quo);
        end else begin
            res = (quo >= lim) ? {1'b0, {(SAMPLE_BITS-1){1'b1}}}
                               : quo[SAMPLE_BITS-1:0];
        end
    end

    assign out_free = !r_ovalid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ws       <= CFG_BITS'(1);
            r_seen     <= '0;
            r_npush    <= '0;
            r_sum      <= '0;
            r_lastitem <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            if (r_ovalid && !i_stall && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cfg_valid) begin
                        r_ws   <= i_cfg_data | CFG_BITS'(1);
                        r_seen <= '0;
                        r_sum  <= '0;
                    end else if (i_valid) begin
                        r_lastitem <= i_end_of_stream;
                        r_npush    <= ((r_seen == '0) ? half : '0) + CFG_BITS'(1)
                                      + (i_end_of_stream ? half : '0);
                        r_state    <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    r_sum   <= n_sum;
                    r_seen  <= n_seen;
                    r_npush <= r_npush - 1'b1;
                    if (n_seen == w_eff) begin
                        r_state <= S_DIV;
                    end else if (r_npush == CFG_BITS'(1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        if (r_npush == '0) begin
                            r_state <= S_IDLE;
                            if (r_lastitem) begin
                                r_seen <= '0;
                                r_sum  <= '0;
                            end
                        end else begin
                            r_state <= S_PUSH;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && !i_cfg_valid && i_valid) begin
            r_smp <= i_sample_in;
        end
        if (div_start) begin
            r_neg <= n_sum[SUM_BITS-1];
        end
        if (r_state == S_OUT && out_free) begin
            r_out   <= res;
            r_olast <= r_lastitem && (r_npush == '0);
        end
    end

    assign o_stall      = (r_state != S_IDLE) || i_cfg_valid;
    assign o_cfg_ready  = (r_state == S_IDLE);
    assign o_valid      = r_ovalid;
    assign o_sample_out = r_out;
    assign o_last_out   = r_olast;

endmodule
